// ===== rtl/afc_pkg.sv =====
// ----------------------------------------------------------------------------
// afc_pkg
// constants and types shared by the acknowledge frame checker modules
// ----------------------------------------------------------------------------
package afc_pkg;

    localparam int unsigned MAX_FRAME_DEF = 64;

    localparam logic [7:0] HDR_A  = 8'h5D;
    localparam logic [7:0] HDR_B  = 8'h6C;
    localparam logic [7:0] TAIL_A = 8'h7E;
    localparam logic [7:0] TAIL_B = 8'h5A;

    localparam int unsigned MIN_LEN      = 6;
    localparam int unsigned LEN_OVERHEAD = 5;

    // byte positions inside a frame; the tail ones are offsets from the length byte value
    localparam int unsigned POS_HDR_A  = 0;
    localparam int unsigned POS_HDR_B  = 1;
    localparam int unsigned POS_LENGTH = 2;
    localparam int unsigned POS_SIZE_H = 3;
    localparam int unsigned POS_SIZE_L = 4;
    localparam int unsigned TAIL_A_OFS = 3;
    localparam int unsigned TAIL_B_OFS = 4;

    localparam int unsigned STATUS_W = 3;
    localparam int unsigned SIZE_W   = 16;

    localparam logic [STATUS_W-1:0] ST_OK     = 3'd0;
    localparam logic [STATUS_W-1:0] ST_SHORT  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_HEADER = 3'd2;
    localparam logic [STATUS_W-1:0] ST_LENGTH = 3'd3;
    localparam logic [STATUS_W-1:0] ST_TAIL   = 3'd4;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SIZE_W-1:0]   package_size;
    } afc_result_t;

endpackage

// ===== rtl/ack_frame_checker.sv =====
// ----------------------------------------------------------------------------
// ack_frame_checker
// streaming check of header, length byte and tail of an acknowledge frame
// ----------------------------------------------------------------------------
// the last byte of a burst is taken into the input register, then its result into the result register
// throughput: one byte per cycle, set by the input and result registers, unless result_stall holds them
// bytes past MAX_FRAME are dropped but a flagged one still ends the burst
// reset (rst_n low, asynchronous) clears the valid flags of both registers and the frame state
module ack_frame_checker import afc_pkg::*; #(
    parameter int unsigned MAX_FRAME = MAX_FRAME_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                byte_valid,
    output logic                byte_stall,
    input  logic [7:0]          data_byte,
    input  logic                end_of_burst,
    output logic                result_valid,
    input  logic                result_stall,
    output logic [STATUS_W-1:0] status,
    output logic [SIZE_W-1:0]   package_size
);

    // input register
    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;

    // result register
    logic        out_valid_reg, out_valid_next;
    afc_result_t out_reg;

    afc_result_t frame_result;
    logic        advance;
    logic        step;

    // the pipe moves whenever the result slot is empty or being drained
    assign advance    = !out_valid_reg || !result_stall;
    assign step       = in_valid_reg && advance;
    // the input register holds only while its item cannot move on
    assign byte_stall = in_valid_reg && !advance;

    always_comb
    begin
        in_valid_next  = in_valid_reg;
        out_valid_next = out_valid_reg;
        if (!byte_stall)
        begin
            in_valid_next = byte_valid;
        end
        if (advance)
        begin
            // only the flagged byte of a burst produces a result item
            out_valid_next = in_valid_reg && in_last_reg;
        end
    end

    afc_frame_state #(
        .MAX_FRAME (MAX_FRAME)
    ) u_frame_state (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (step),
        .data_byte    (in_byte_reg),
        .end_of_burst (in_last_reg),
        .result       (frame_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (!byte_stall && byte_valid)
        begin
            in_byte_reg <= data_byte;
            in_last_reg <= end_of_burst;
        end
        if (step && in_last_reg)
        begin
            out_reg <= frame_result;
        end
    end

    assign result_valid = out_valid_reg;
    assign status       = out_reg.status;
    assign package_size = out_reg.package_size;

endmodule

// ===== rtl/afc_frame_state.sv =====
// ----------------------------------------------------------------------------
// afc_frame_state
// per-burst position counter, header/length/tail checks and result decode
// ----------------------------------------------------------------------------
module afc_frame_state import afc_pkg::*; #(
    parameter int unsigned MAX_FRAME = MAX_FRAME_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [7:0]        data_byte,
    input  logic              end_of_burst,
    output afc_result_t       result
);

    localparam int unsigned CNT_W = $clog2(MAX_FRAME + 1);
    localparam int unsigned CMP_W = 10;

    logic [CNT_W-1:0] count_reg, count_next, count_upd;
    logic             header_reg, header_next, header_upd;
    logic [7:0]       length_reg, length_next, length_upd;
    logic             tail_reg, tail_next, tail_upd;
    logic [7:0]       size_h_reg, size_h_next, size_h_upd;
    logic [7:0]       size_l_reg, size_l_next, size_l_upd;

    logic             keep;
    logic [CMP_W-1:0] pos_ext;
    logic [CMP_W-1:0] tail_a_pos;
    logic [CMP_W-1:0] tail_b_pos;
    logic [CMP_W-1:0] frame_len;

    always_comb
    begin
        keep       = count_reg < CNT_W'(MAX_FRAME);
        pos_ext    = CMP_W'(count_reg);
        tail_a_pos = CMP_W'(length_reg) + CMP_W'(TAIL_A_OFS);
        tail_b_pos = CMP_W'(length_reg) + CMP_W'(TAIL_B_OFS);

        count_upd  = count_reg;
        header_upd = header_reg;
        length_upd = length_reg;
        tail_upd   = tail_reg;
        size_h_upd = size_h_reg;
        size_l_upd = size_l_reg;

        if (keep)
        begin
            count_upd = count_reg + CNT_W'(1);
            if (count_reg == CNT_W'(POS_HDR_A) && data_byte != HDR_A)
            begin
                header_upd = 1'b0;
            end
            if (count_reg == CNT_W'(POS_HDR_B) && data_byte != HDR_B)
            begin
                header_upd = 1'b0;
            end
            if (count_reg == CNT_W'(POS_LENGTH))
            begin
                length_upd = data_byte;
            end
            if (count_reg == CNT_W'(POS_SIZE_H))
            begin
                size_h_upd = data_byte;
            end
            if (count_reg == CNT_W'(POS_SIZE_L))
            begin
                size_l_upd = data_byte;
            end
            // tail positions follow the length byte, so only from byte 3 on
            if (count_reg >= CNT_W'(TAIL_A_OFS))
            begin
                if (pos_ext == tail_a_pos && data_byte != TAIL_A)
                begin
                    tail_upd = 1'b0;
                end
                if (pos_ext == tail_b_pos && data_byte != TAIL_B)
                begin
                    tail_upd = 1'b0;
                end
            end
        end

        // checks in priority order on the updated state
        frame_len           = CMP_W'(length_upd) + CMP_W'(LEN_OVERHEAD);
        result.package_size = '0;
        if (count_upd < CNT_W'(MIN_LEN))
        begin
            result.status = ST_SHORT;
        end
        else if (!header_upd)
        begin
            result.status = ST_HEADER;
        end
        else if (CMP_W'(count_upd) != frame_len)
        begin
            result.status = ST_LENGTH;
        end
        else if (!tail_upd)
        begin
            result.status = ST_TAIL;
        end
        else
        begin
            result.status       = ST_OK;
            result.package_size = {size_h_upd, size_l_upd};
        end

        // hold when idle, update on each stepped byte, clear after the last byte of a burst
        count_next  = count_reg;
        header_next = header_reg;
        length_next = length_reg;
        tail_next   = tail_reg;
        size_h_next = size_h_reg;
        size_l_next = size_l_reg;
        if (step)
        begin
            if (end_of_burst)
            begin
                count_next  = '0;
                header_next = 1'b1;
                length_next = '0;
                tail_next   = 1'b1;
                size_h_next = '0;
                size_l_next = '0;
            end
            else
            begin
                count_next  = count_upd;
                header_next = header_upd;
                length_next = length_upd;
                tail_next   = tail_upd;
                size_h_next = size_h_upd;
                size_l_next = size_l_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            header_reg <= 1'b1;
            length_reg <= '0;
            tail_reg   <= 1'b1;
            size_h_reg <= '0;
            size_l_reg <= '0;
        end
        else
        begin
            count_reg  <= count_next;
            header_reg <= header_next;
            length_reg <= length_next;
            tail_reg   <= tail_next;
            size_h_reg <= size_h_next;
            size_l_reg <= size_l_next;
        end
    end

endmodule
